>>> rtl/psau_pkg.sv
// ----------------------------------------------------------------------------
// Pointer smoother package
// Widths, reset values, register indexes and the command and status words
// shared by the pointer smoother modules.
// ----------------------------------------------------------------------------
package psau_pkg;

  localparam int FIN_W = 12;
  localparam int SCR_W = 14;
  localparam int POS_W = 16;
  localparam int TGT_W = 14;
  localparam int SUM_W = 22;
  localparam int DVD_W = 31;
  localparam int DVS_W = 17;
  localparam int QUO_W = 15;
  localparam int NUM_AX = 2;
  localparam int AX_X = 0;
  localparam int AX_Y = 1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic [SCR_W-1:0] WIDTH_RESET = 14'd1920;
  localparam logic [SCR_W-1:0] HEIGHT_RESET = 14'd1080;
  localparam int DAMP_DIV = 100;

  // The damping division by 100 is a multiply by 2**28/100 rounded up, a scaled
  // reciprocal, exact for every magnitude that the damping sum can reach.
  localparam int DAMP_SHIFT = 28;
  localparam logic [SUM_W-1:0] DAMP_RECIP = 22'd2684355;

  typedef struct packed {
    logic capture;
    logic load;
    logic damp;
    logic div_start;
    logic update;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic usable;
    logic div_done;
    logic span_ok;
  } stat_t;

  // Scaled target: X by 9/4 and Y by 15/8, truncated.
  function automatic logic [TGT_W-1:0] target_of(input int lane,
                                                 input logic [FIN_W-1:0] f);
    logic [FIN_W+3:0] m;
    logic [FIN_W+3:0] fe;
    fe = {4'b0000, f};
    if (lane == AX_X) begin
      m = ((fe << 3) + fe) >> 2;
    end else begin
      m = ((fe << 4) - fe) >> 3;
    end
    return m[TGT_W-1:0];
  endfunction

endpackage

>>> rtl/psau_if.sv
// ----------------------------------------------------------------------------
// Pointer smoother channels
// Valid/ready channels for the fingertip sample and the cursor result.
// ----------------------------------------------------------------------------
interface psau_in_if;
  import psau_pkg::*;
  logic valid;
  logic ready;
  logic [FIN_W-1:0] finger_x;
  logic [FIN_W-1:0] finger_y;
  modport source (output valid, output finger_x, output finger_y, input ready);
  modport sink (input valid, input finger_x, input finger_y, output ready);
endinterface

interface psau_out_if;
  import psau_pkg::*;
  logic valid;
  logic ready;
  logic [SCR_W-1:0] cursor_x;
  logic [SCR_W-1:0] cursor_y;
  modport source (output valid, output cursor_x, output cursor_y, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, output ready);
endinterface

>>> rtl/pointer_smoother_autorange_unit.sv
// ----------------------------------------------------------------------------
// Pointer smoother with autorange
// Damped cursor follower that learns the fingertip range and maps it to the
// screen.
// ----------------------------------------------------------------------------
// A sample with a zero coordinate is taken while idle and gives no word.
// A usable sample that gives a word runs through these steps before the
// next sample can be taken: the damping sum, the reciprocal multiply that
// divides it by 100, the state update and the scaling multiply, the start
// of the per-axis 15-step normalization divider, the wait until it reports
// done, the load of the output register and the return to idle, both axes
// in parallel. When a span is still empty the sample ends after the scaling
// multiply and goes back to idle with no word. The result sits in an output
// register, so a new sample is taken while the last word waits; the block
// stalls only when a second result is ready before the first was taken.
// ----------------------------------------------------------------------------
module pointer_smoother_autorange_unit (
  input  logic                           clk,
  input  logic                           rst,
  psau_in_if.sink                        in_ch,
  psau_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [psau_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psau_pkg::SCR_W-1:0]     cfg_data
);
  import psau_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  psau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psau_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .finger_x  (in_ch.finger_x),
    .finger_y  (in_ch.finger_y),
    .cursor_x  (out_ch.cursor_x),
    .cursor_y  (out_ch.cursor_y),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

>>> rtl/psau_div.sv
// ----------------------------------------------------------------------------
// Pointer smoother divider
// Restoring unsigned divider, one quotient bit per cycle. The caller keeps
// the quotient below 2**QUO_W, so only QUO_W steps are run.
// ----------------------------------------------------------------------------
module psau_div #(
  parameter int DVD_W = psau_pkg::DVD_W,
  parameter int DVS_W = psau_pkg::DVS_W,
  parameter int QUO_W = psau_pkg::QUO_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient,
  output logic             done
);
  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [QUO_W-1:0] dsh;
  logic [QUO_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem, dsh[QUO_W-1]};
  assign diff = trial - {1'b0, dvs};
  assign fits = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DVS_W'(dividend[DVD_W-1:QUO_W]);
      dsh <= dividend[QUO_W-1:0];
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dsh <= {dsh[QUO_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule

>>> rtl/psau_ctrl.sv
// ----------------------------------------------------------------------------
// Pointer smoother controller
// Sequences one sample through damping, tracking and normalization, and
// owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module psau_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  psau_pkg::stat_t stat,
  output psau_pkg::cmd_t  cmd
);
  import psau_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_DAMP   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_NSTART = 3'd5;
  localparam logic [2:0] S_NWAIT  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && stat.usable) begin
          cmd.capture = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        state_next = S_DAMP;
      end
      S_DAMP: begin
        cmd.damp = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = stat.span_ok ? S_NSTART : S_IDLE;
      end
      S_NSTART: begin
        cmd.div_start = 1'b1;
        state_next = S_NWAIT;
      end
      S_NWAIT: begin
        if (stat.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/psau_dp.sv
// ----------------------------------------------------------------------------
// Pointer smoother datapath
// Screen size registers and one lane per axis: damped follower with a
// reciprocal multiply for the damping, range tracker, scaling multiplier
// and a divider for the normalization.
// ----------------------------------------------------------------------------
module psau_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [psau_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psau_pkg::SCR_W-1:0]     cfg_data,
  input  logic [psau_pkg::FIN_W-1:0]     finger_x,
  input  logic [psau_pkg::FIN_W-1:0]     finger_y,
  output logic [psau_pkg::SCR_W-1:0]     cursor_x,
  output logic [psau_pkg::SCR_W-1:0]     cursor_y,
  input  psau_pkg::cmd_t                 cmd,
  output psau_pkg::stat_t                stat
);
  import psau_pkg::*;

  logic [SCR_W-1:0] scr [NUM_AX];
  logic [FIN_W-1:0] fin_in [NUM_AX];
  logic [SCR_W-1:0] cur [NUM_AX];
  logic             lane_ok [NUM_AX];
  logic             lane_done [NUM_AX];

  assign fin_in[AX_X] = finger_x;
  assign fin_in[AX_Y] = finger_y;
  assign cursor_x = cur[AX_X];
  assign cursor_y = cur[AX_Y];

  assign stat.usable = (finger_x != '0) && (finger_y != '0);
  assign stat.div_done = lane_done[AX_X] && lane_done[AX_Y];
  assign stat.span_ok = lane_ok[AX_X] && lane_ok[AX_Y];

  always_ff @(posedge clk) begin
    if (rst) begin
      scr[AX_X] <= WIDTH_RESET;
      scr[AX_Y] <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH: scr[AX_X] <= cfg_data;
        REG_HEIGHT: scr[AX_Y] <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_AX; g++) begin : g_ax
    localparam logic [POS_W-1:0] MIN_RESET =
      (g == AX_X) ? POS_W'(WIDTH_RESET) : POS_W'(HEIGHT_RESET);

    logic [FIN_W-1:0]        fin;
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] vel;
    logic signed [POS_W-1:0] mn;
    logic signed [POS_W-1:0] mx;
    logic                    neg;
    logic [SUM_W-1:0]        mag;
    logic [2*SUM_W-1:0]      vprod;
    logic [POS_W-1:0]        vq;
    logic [DVD_W-1:0]        num;
    logic [DVS_W-1:0]        span;
    logic [TGT_W-1:0]        tgt;
    logic [POS_W:0]          diff;
    logic [SUM_W-1:0]        dext;
    logic [SUM_W-1:0]        vext;
    logic [SUM_W-1:0]        sum;
    logic signed [POS_W-1:0] vmag;
    logic signed [POS_W-1:0] vnew;
    logic signed [POS_W-1:0] pnew;
    logic [POS_W-1:0]        off;
    logic [POS_W-1:0]        spn;
    logic [SCR_W+POS_W-1:0]  prod;
    logic [QUO_W-1:0]        quo;
    logic                    dn;

    assign tgt = target_of(g, fin);
    assign diff = {{(POS_W+1-TGT_W){1'b0}}, tgt} - {pos[POS_W-1], pos};
    assign dext = {{(SUM_W-POS_W-1){diff[POS_W]}}, diff};
    assign vext = {{(SUM_W-POS_W){vel[POS_W-1]}}, vel};
    // Gain 16/100 on the distance and friction 40/100 on the velocity.
    assign sum = (dext << 4) + (vext << 5) + (vext << 3);

    assign vprod = mag * DAMP_RECIP;
    assign vmag = vq;
    assign vnew = neg ? -vmag : vmag;
    assign pnew = pos + vnew;

    assign off = pos - mn;
    assign spn = mx - mn;
    assign prod = scr[g] * off;
    assign lane_ok[g] = mx > mn;
    assign lane_done[g] = dn;

    psau_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W),
      .QUO_W (QUO_W)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_start),
      .dividend (num),
      .divisor  (span),
      .quotient (quo),
      .done     (dn)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        pos <= '0;
        vel <= '0;
        mn <= MIN_RESET;
        mx <= '0;
      end else if (cmd.update) begin
        vel <= vnew;
        pos <= pnew;
        if (pnew < mn) begin
          mn <= pnew;
        end
        if (pnew > mx) begin
          mx <= pnew;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        fin <= fin_in[g];
      end
      if (cmd.load) begin
        neg <= sum[SUM_W-1];
        mag <= sum[SUM_W-1] ? -sum : sum;
      end
      if (cmd.damp) begin
        vq <= vprod[DAMP_SHIFT +: POS_W];
      end
      if (cmd.mul) begin
        span <= DVS_W'(spn);
        if (g == AX_X) begin
          // Ceiling division on the mirrored axis.
          num <= DVD_W'(prod) + DVD_W'(spn) - DVD_W'(1);
        end else begin
          num <= DVD_W'(prod);
        end
      end
      if (cmd.out_load) begin
        if (g == AX_X) begin
          cur[g] <= scr[g] - SCR_W'(quo);
        end else begin
          cur[g] <= SCR_W'(quo);
        end
      end
    end
  end

endmodule

>>> rtl/psau_checker.sv
// ----------------------------------------------------------------------------
// Pointer smoother checker
// Port-level assertions on the handshakes and sequencing of the block.
// ----------------------------------------------------------------------------
module psau_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [psau_pkg::FIN_W-1:0] finger_x,
  input logic [psau_pkg::FIN_W-1:0] finger_y,
  input logic                       out_valid,
  input logic                       out_ready
);
  import psau_pkg::*;

  // A pending word stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

  // A usable sample occupies the block, so the next cycle takes no sample.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (finger_x != '0) && (finger_y != '0) |=> !in_ready)
    else $error("sample taken while a usable sample is in work");

  // A new word appears only at the end of a sample, never while idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("output word appeared without a sample in work");

  // Reset leaves the block idle with no word pending.
  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind pointer_smoother_autorange_unit psau_checker u_psau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .finger_x  (in_ch.finger_x),
  .finger_y  (in_ch.finger_y),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pointer smoother testbench
// Sends fingertip samples with random bursts and gaps while the cursor side
// stalls on patterns of its own. A cursor tracker predicts every word from
// its own damped follower and range tracker and checks each accepted word
// against the oldest prediction. The screen size is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
  import psau_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_GUARD = 60;
  localparam int NUM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int NUM_DIRECTED = 20;
  localparam int Q_IDX_W = 4;
  localparam int Q_DEPTH = 1 << Q_IDX_W;
  localparam logic [FIN_W-1:0] FIN_MAX = 12'hFFF;

  typedef struct packed {
    logic [SCR_W-1:0] cx;
    logic [SCR_W-1:0] cy;
  } cursor_word_t;

  class cursor_tracker;
    logic [SCR_W-1:0] scr_w;
    logic [SCR_W-1:0] scr_h;
    logic signed [POS_W-1:0] pos [NUM_AX];
    logic signed [POS_W-1:0] vel [NUM_AX];
    logic signed [POS_W-1:0] lo [NUM_AX];
    logic signed [POS_W-1:0] hi [NUM_AX];
    cursor_word_t want_q [Q_DEPTH];
    logic [Q_IDX_W-1:0] q_head;
    logic [Q_IDX_W-1:0] q_tail;
    int q_count;
    int errors;

    function new();
      scr_w = WIDTH_RESET;
      scr_h = HEIGHT_RESET;
      foreach (pos[a]) begin
        pos[a] = '0;
        vel[a] = '0;
        hi[a] = '0;
      end
      lo[AX_X] = POS_W'(WIDTH_RESET);
      lo[AX_Y] = POS_W'(HEIGHT_RESET);
      q_head = '0;
      q_tail = '0;
      q_count = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SCR_W-1:0] val);
      case (idx)
        REG_WIDTH: scr_w = val;
        REG_HEIGHT: scr_h = val;
        default: ;
      endcase
    endfunction

    function void report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    function void advance_axis(int ax, int target);
      int d;
      int nv;
      d = target - int'(pos[ax]);
      nv = (16 * d + 40 * int'(vel[ax])) / DAMP_DIV;
      vel[ax] = nv[POS_W-1:0];
      pos[ax] = pos[ax] + vel[ax];
      if (pos[ax] < lo[ax]) lo[ax] = pos[ax];
      if (pos[ax] > hi[ax]) hi[ax] = pos[ax];
    endfunction

    function void note_sample(logic [FIN_W-1:0] fx, logic [FIN_W-1:0] fy);
      int span_x;
      int span_y;
      longint w;
      longint h;
      longint nx;
      longint ny;
      longint cx;
      longint cy;
      cursor_word_t word;
      if (fx == 0 || fy == 0) return;
      advance_axis(AX_X, (int'(fx) * 9) / 4);
      advance_axis(AX_Y, (int'(fy) * 15) / 8);
      span_x = int'(hi[AX_X]) - int'(lo[AX_X]);
      span_y = int'(hi[AX_Y]) - int'(lo[AX_Y]);
      if (span_x <= 0 || span_y <= 0) return;
      w = longint'(scr_w);
      h = longint'(scr_h);
      nx = w * longint'(int'(pos[AX_X]) - int'(lo[AX_X]));
      ny = h * longint'(int'(pos[AX_Y]) - int'(lo[AX_Y]));
      cx = w - (nx + longint'(span_x) - 1) / longint'(span_x);
      cy = ny / longint'(span_y);
      if (cx < 0) cx = 0;
      if (cy < 0) cy = 0;
      word.cx = cx[SCR_W-1:0];
      word.cy = cy[SCR_W-1:0];
      if (q_count == Q_DEPTH) begin
        report_mismatch("too many predicted words waiting");
        return;
      end
      want_q[q_tail] = word;
      q_tail = q_tail + 1'b1;
      q_count++;
    endfunction

    task check_word(logic [SCR_W-1:0] cx, logic [SCR_W-1:0] cy);
      cursor_word_t want;
      if (q_count == 0) begin
        report_mismatch($sformatf("unexpected word x=%0d y=%0d", cx, cy));
        return;
      end
      want = want_q[q_head];
      q_head = q_head + 1'b1;
      q_count--;
      if (cx !== want.cx)
        report_mismatch($sformatf("cursor_x %0d, predicted %0d", cx, want.cx));
      if (cy !== want.cy)
        report_mismatch($sformatf("cursor_y %0d, predicted %0d", cy, want.cy));
    endtask

    function int pending();
      return q_count;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [SCR_W-1:0] cfg_data = '0;
  logic rx_ready = 1'b0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold = 0;
  int cycle_count = 0;
  int burst_left = 0;
  logic [FIN_W-1:0] last_x = 12'd1;
  logic [FIN_W-1:0] last_y = 12'd1;

  logic [FIN_W-1:0] directed_x [NUM_DIRECTED] = '{
    12'd0, 12'd0, FIN_MAX, FIN_MAX, 12'd1, FIN_MAX, FIN_MAX, 12'd1, 12'd1, 12'd2048,
    FIN_MAX, 12'd1, 12'hAAA, 12'h555, 12'd3000, FIN_MAX, 12'd1, 12'd0, FIN_MAX, 12'd1
  };
  logic [FIN_W-1:0] directed_y [NUM_DIRECTED] = '{
    12'd0, FIN_MAX, 12'd0, FIN_MAX, 12'd1, FIN_MAX, 12'd1, FIN_MAX, 12'd1, 12'd2048,
    FIN_MAX, 12'd1, 12'h555, 12'hAAA, 12'd500, FIN_MAX, 12'd1, 12'd100, FIN_MAX, 12'd1
  };
  int phase_w [NUM_PHASES] = '{1920, 1, 8192, 0, 640, 8192, 0};
  int phase_h [NUM_PHASES] = '{1080, 8192, 1, 700, 0, 8192, 0};

  cursor_tracker tracker = new();

  psau_in_if in_ch ();
  psau_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  pointer_smoother_autorange_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(32, 256);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= 1'($urandom_range(0, 1));
      2: rx_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_ready <= ~rx_ready;
          rx_hold <= $urandom_range(1, 40);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) tracker.check_word(out_ch.cursor_x, out_ch.cursor_y);
  end

  task automatic send_sample(input logic [FIN_W-1:0] fx, input logic [FIN_W-1:0] fy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid <= 1'b1;
    in_ch.finger_x <= fx;
    in_ch.finger_y <= fy;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_sample(fx, fy);
    burst_left--;
  endtask

  task automatic set_screen(input logic [SCR_W-1:0] w, input logic [SCR_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(REG_WIDTH, w);
    tracker.set_reg(REG_HEIGHT, h);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  // Mostly fresh positions, with held positions that let the follower settle,
  // extremes that stretch the range, and samples with a zero coordinate.
  task automatic random_sample(output logic [FIN_W-1:0] fx, output logic [FIN_W-1:0] fy);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      fx = ($urandom_range(0, 2) == 0) ? 12'd0 : FIN_W'($urandom_range(0, 4095));
      fy = (fx != 0) ? 12'd0 : FIN_W'($urandom_range(0, 4095));
    end else if (pick < 25) begin
      fx = last_x;
      fy = last_y;
    end else if (pick < 40) begin
      fx = ($urandom_range(0, 1) == 0) ? 12'd1 : FIN_MAX;
      fy = ($urandom_range(0, 1) == 0) ? 12'd1 : FIN_MAX;
    end else begin
      fx = FIN_W'($urandom_range(1, 4095));
      fy = FIN_W'($urandom_range(1, 4095));
    end
    if (fx != 0 && fy != 0) begin
      last_x = fx;
      last_y = fy;
    end
  endtask

  initial begin
    logic [FIN_W-1:0] fx;
    logic [FIN_W-1:0] fy;
    int used;
    in_ch.valid <= 1'b0;
    in_ch.finger_x <= '0;
    in_ch.finger_y <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        phase_w[p] = $urandom_range(1, 8192);
        phase_h[p] = $urandom_range(1, 8192);
      end
      set_screen(SCR_W'(phase_w[p]), SCR_W'(phase_h[p]));
      if (p == 0) begin
        for (int i = 0; i < NUM_DIRECTED; i++) send_sample(directed_x[i], directed_y[i]);
      end
      used = 0;
      while (used < ITEMS_PER_PHASE) begin
        random_sample(fx, fy);
        send_sample(fx, fy);
        if (fx != 0 && fy != 0) used++;
      end
      wait_idle();
    end
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
